@@ rtl/integer_to_ascii_field_formatter_macros.svh @@
// assertion macros for the integer to ascii field formatter
`ifndef INTEGER_TO_ASCII_FIELD_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FIELD_FORMATTER_MACROS_SVH

// same-cycle implication
`define I2A_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("i2a assertion failed");

// next-cycle implication
`define I2A_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("i2a assertion failed");

`endif

@@ rtl/i2a_pkg.sv @@
// shared types, constants and helpers of the integer to ascii field formatter
package i2a_pkg;

    localparam int MAX_WIDTH_DEF = 63;
    localparam int VAL_W         = 32;
    localparam int DIG_W         = 4;
    localparam int NDIG          = 11;
    localparam int DIG_BITS      = NDIG * DIG_W;
    localparam int BCD_DIGS      = 10;
    localparam int OCT_DIGS      = 11;
    localparam int LEN_W         = 6;

    localparam logic [LEN_W-1:0] PREC_MAX = 6'd40;
    localparam logic [LEN_W-1:0] PREC_PTR = 6'd4;

    typedef logic [1:0] base_t;
    localparam base_t BASE_DEC = 2'd0;
    localparam base_t BASE_HEX = 2'd1;
    localparam base_t BASE_OCT = 2'd2;

    localparam logic [2:0] FUNC_SDEC = 3'd0;
    localparam logic [2:0] FUNC_UDEC = 3'd1;
    localparam logic [2:0] FUNC_HEXL = 3'd2;
    localparam logic [2:0] FUNC_HEXU = 3'd3;
    localparam logic [2:0] FUNC_OCT  = 3'd4;
    localparam logic [2:0] FUNC_PTR  = 3'd5;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_PLUS  = 7'h2b;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A_UP  = 7'h41;
    localparam logic [6:0] CH_X_UP  = 7'h58;
    localparam logic [6:0] CH_A_LO  = 7'h61;
    localparam logic [6:0] CH_X_LO  = 7'h78;

    typedef struct packed {
        base_t            base;
        logic             neg;
        logic             upper;
        logic             alt;
        logic             plus;
        logic             space;
        logic             left;
        logic             zflag;
        logic             prec_none;
        logic [LEN_W-1:0] prec;
        logic [LEN_W-1:0] width;
    } fld_spec_t;

    typedef struct packed {
        logic             done;
        logic [3:0]       count;
        logic [DIG_W-1:0] digit;
        logic             is_zero;
    } conv_stat_t;

    function automatic logic [6:0] dig_char(input logic [DIG_W-1:0] d, input logic upper);
        logic [6:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {3'b000, d};
        end
        else
        begin
            c = (upper ? CH_A_UP : CH_A_LO) + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

@@ rtl/i2a_conv.sv @@
// digit converter: bit-serial binary to bcd, digit split for hex and octal, leading zero strip
`include "integer_to_ascii_field_formatter_macros.svh"

module i2a_conv (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  i2a_pkg::base_t         base_sel,
    input  logic [31:0]            mag,
    input  logic                   shift,
    output i2a_pkg::conv_stat_t    stat
);
    import i2a_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DABBLE = 2'd1;
    localparam logic [1:0] ST_NORM   = 2'd2;
    localparam logic [1:0] ST_HOLD   = 2'd3;

    logic [1:0]          state_reg;
    logic [4:0]          bit_reg;
    logic [3:0]          cnt_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [DIG_BITS-1:0] dig_reg;

    logic [DIG_BITS-1:0]    oct_dig;
    logic [VAL_W:0]         oct_src;
    logic [BCD_DIGS*4-1:0]  bcd_adj;
    logic [DIG_W-1:0]       top_dig;
    logic                   norm_more;

    always_comb
    begin
        oct_src = {1'b0, mag};
        for (int i = 0; i < OCT_DIGS; i++)
        begin
            oct_dig[i*4 +: 4] = {1'b0, oct_src[i*3 +: 3]};
        end
    end

    // add-3 correction on every bcd digit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGS; i++)
        begin
            bcd_adj[i*4 +: 4] = (dig_reg[i*4 +: 4] >= 4'd5) ?
                                dig_reg[i*4 +: 4] + 4'd3 : dig_reg[i*4 +: 4];
        end
    end

    assign top_dig   = dig_reg[DIG_BITS-1 -: DIG_W];
    assign norm_more = (cnt_reg > 4'd1) && (top_dig == 4'd0);

    assign stat.done    = (state_reg == ST_NORM) && !norm_more;
    assign stat.count   = cnt_reg;
    assign stat.digit   = top_dig;
    assign stat.is_zero = (cnt_reg == 4'd1) && (top_dig == 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= 5'd0;
            cnt_reg   <= 4'd0;
        end
        else if (start)
        begin
            state_reg <= (base_sel == BASE_DEC) ? ST_DABBLE : ST_NORM;
            bit_reg   <= 5'd31;
            cnt_reg   <= 4'(NDIG);
        end
        else
        begin
            unique case (state_reg)
                ST_DABBLE:
                begin
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0)
                    begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (norm_more)
                    begin
                        cnt_reg <= cnt_reg - 4'd1;
                    end
                    else
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    state_reg <= ST_HOLD;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= mag;
            if (base_sel == BASE_DEC)
            begin
                dig_reg <= '0;
            end
            else if (base_sel == BASE_HEX)
            begin
                dig_reg <= {12'd0, mag};
            end
            else
            begin
                dig_reg <= oct_dig;
            end
        end
        else if (state_reg == ST_DABBLE)
        begin
            dig_reg <= {4'd0, bcd_adj[BCD_DIGS*4-2:0], val_reg[VAL_W-1]};
            val_reg <= {val_reg[VAL_W-2:0], 1'b0};
        end
        else if ((state_reg == ST_NORM && norm_more) || (state_reg == ST_HOLD && shift))
        begin
            dig_reg <= {dig_reg[DIG_BITS-DIG_W-1:0], 4'd0};
        end
    end

    `I2A_ASSERT_IMPL(a_norm_cnt_nonzero, clk, rst_n, state_reg == ST_NORM, cnt_reg != 4'd0)
    `I2A_ASSERT_NEXT(a_dabble_to_norm, clk, rst_n, state_reg == ST_DABBLE && bit_reg == 5'd0 && !start, state_reg == ST_NORM)

endmodule

@@ rtl/i2a_emit.sv @@
// field assembler: sign, prefix, zeros, digits and padding, one character per transaction
`include "integer_to_ascii_field_formatter_macros.svh"

module i2a_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  i2a_pkg::fld_spec_t     spec,
    input  i2a_pkg::conv_stat_t    stat,
    output logic                   shift,
    output logic                   done,
    output logic [6:0]             out_char,
    output logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready
);
    import i2a_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0]       state_reg;
    logic [3:0]       count_reg;
    logic             zero_reg;
    logic [LEN_W-1:0] zeros_reg;
    logic             sign_reg;
    logic             pfx0_reg;
    logic             pfxx_reg;
    logic [LEN_W-1:0] body_reg;
    logic [LEN_W-1:0] lpad_reg;
    logic [LEN_W-1:0] rpad_reg;
    logic [LEN_W-1:0] remain_reg;
    logic [6:0]       char_reg;
    logic             last_reg;
    logic             valid_reg;

    logic [3:0]       count_next;
    logic [LEN_W-1:0] zeros_next;
    logic             sign_next;
    logic             pfx0_next;
    logic             pfxx_next;
    logic [LEN_W-1:0] lpad_next;
    logic [LEN_W-1:0] rpad_next;

    logic [3:0]       cnt_eff;
    logic [LEN_W-1:0] zeros_calc;
    logic             sign_on;
    logic             pfx_hex;
    logic             pfx_oct;
    logic [LEN_W-1:0] body_calc;
    logic             wide;
    logic [LEN_W-1:0] pad;
    logic [LEN_W-1:0] remain_calc;
    logic             zfill;
    logic             emit;
    logic             dig_seg;
    logic [6:0]       char_sel;
    logic [6:0]       sign_ch;

    // zero value with precision zero has no digits
    assign cnt_eff = (stat.is_zero && !spec.prec_none && spec.prec == '0) ? 4'd0 : stat.count;

    assign zeros_calc = (!spec.prec_none && spec.prec > {2'b00, count_reg}) ?
                        spec.prec - {2'b00, count_reg} : '0;
    assign sign_on    = spec.neg || spec.plus || spec.space;
    assign sign_ch    = spec.neg ? CH_MINUS : (spec.plus ? CH_PLUS : CH_SPACE);
    assign pfx_hex    = spec.alt && spec.base == BASE_HEX && !zero_reg;
    assign pfx_oct    = spec.alt && spec.base == BASE_OCT && zeros_calc == '0 &&
                        (!zero_reg || count_reg == 4'd0);
    assign body_calc  = {2'b00, count_reg} + zeros_calc + {5'd0, sign_on} +
                        {5'd0, pfx_hex || pfx_oct} + {5'd0, pfx_hex};

    assign wide        = spec.width > body_reg;
    assign pad         = wide ? spec.width - body_reg : '0;
    assign remain_calc = wide ? spec.width : body_reg;
    assign zfill       = !spec.left && spec.zflag && spec.prec_none && wide;

    assign emit  = (state_reg == ST_RUN) && (!valid_reg || out_ready);
    assign shift = emit && dig_seg;
    assign done  = (state_reg == ST_PAD && remain_calc == '0) ||
                   (emit && remain_reg == 6'd1);

    always_comb
    begin
        char_sel   = CH_SPACE;
        dig_seg    = 1'b0;
        count_next = count_reg;
        zeros_next = zeros_reg;
        sign_next  = sign_reg;
        pfx0_next  = pfx0_reg;
        pfxx_next  = pfxx_reg;
        lpad_next  = lpad_reg;
        rpad_next  = rpad_reg;
        if (lpad_reg != '0)
        begin
            char_sel  = CH_SPACE;
            lpad_next = lpad_reg - 6'd1;
        end
        else if (sign_reg)
        begin
            char_sel  = sign_ch;
            sign_next = 1'b0;
        end
        else if (pfx0_reg)
        begin
            char_sel  = CH_ZERO;
            pfx0_next = 1'b0;
        end
        else if (pfxx_reg)
        begin
            char_sel  = spec.upper ? CH_X_UP : CH_X_LO;
            pfxx_next = 1'b0;
        end
        else if (zeros_reg != '0)
        begin
            char_sel   = CH_ZERO;
            zeros_next = zeros_reg - 6'd1;
        end
        else if (count_reg != 4'd0)
        begin
            char_sel   = dig_char(stat.digit, spec.upper);
            count_next = count_reg - 4'd1;
            dig_seg    = 1'b1;
        end
        else
        begin
            char_sel  = CH_SPACE;
            rpad_next = (rpad_reg != '0) ? rpad_reg - 6'd1 : rpad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= 1'b0;
            count_reg  <= 4'd0;
            zero_reg   <= 1'b0;
            zeros_reg  <= '0;
            sign_reg   <= 1'b0;
            pfx0_reg   <= 1'b0;
            pfxx_reg   <= 1'b0;
            body_reg   <= '0;
            lpad_reg   <= '0;
            rpad_reg   <= '0;
            remain_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (stat.done)
                    begin
                        count_reg <= cnt_eff;
                        zero_reg  <= stat.is_zero;
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    zeros_reg <= zeros_calc;
                    sign_reg  <= sign_on;
                    pfx0_reg  <= pfx_hex || pfx_oct;
                    pfxx_reg  <= pfx_hex;
                    body_reg  <= body_calc;
                    state_reg <= ST_PAD;
                end
                ST_PAD:
                begin
                    remain_reg <= remain_calc;
                    if (zfill)
                    begin
                        zeros_reg <= zeros_reg + pad;
                        lpad_reg  <= '0;
                        rpad_reg  <= '0;
                    end
                    else
                    begin
                        lpad_reg <= spec.left ? '0 : pad;
                        rpad_reg <= spec.left ? pad : '0;
                    end
                    state_reg <= (remain_calc == '0) ? ST_IDLE : ST_RUN;
                end
                ST_RUN:
                begin
                    if (emit)
                    begin
                        count_reg  <= count_next;
                        zeros_reg  <= zeros_next;
                        sign_reg   <= sign_next;
                        pfx0_reg   <= pfx0_next;
                        pfxx_reg   <= pfxx_next;
                        lpad_reg   <= lpad_next;
                        rpad_reg   <= rpad_next;
                        remain_reg <= remain_reg - 6'd1;
                        if (remain_reg == 6'd1)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg <= char_sel;
            last_reg <= (remain_reg == 6'd1);
        end
    end

    assign out_char  = char_reg;
    assign last      = last_reg;
    assign out_valid = valid_reg;

    `I2A_ASSERT_IMPL(a_valid_from_run, clk, rst_n, $rose(valid_reg), $past(state_reg) == ST_RUN)
    `I2A_ASSERT_IMPL(a_run_remain, clk, rst_n, state_reg == ST_RUN, remain_reg != '0)
    `I2A_ASSERT_NEXT(a_last_ends_field, clk, rst_n, emit && remain_reg == 6'd1, state_reg == ST_IDLE && last_reg)

endmodule

@@ rtl/integer_to_ascii_field_formatter.sv @@
// top level of the integer to ascii field formatter
// usage:
//   input channel (in_valid/in_ready) takes one transaction: func, value, width,
//   precision and flags. output channel (out_valid/out_ready) returns the field
//   one ascii character per transaction, with last on the final character.
//   a field of no characters (zero value, precision 0, width 0) returns nothing.
// flow:
//   decimal runs a bit-serial binary to bcd pass, then strips leading zeros
//   one digit per cycle, then the emitter steps through its idle (capture), calc
//   and pad states and loads the first character into the output register;
//   hex and octal skip the bcd pass.
// throughput:
//   one character per cycle while out_ready is high; a new input transaction
//   is taken in the cycle after the last character is loaded into the output
//   register.
// stall: a low out_ready holds the current character and freezes the field.
// reset: rst_n clears all control state; no output is valid after reset.
module integer_to_ascii_field_formatter #(
    parameter int MAX_WIDTH = i2a_pkg::MAX_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        func,
    input  logic [31:0]       value,
    input  logic [5:0]        width,
    input  logic signed [6:0] precision,
    input  logic              flag_left,
    input  logic              flag_zero,
    input  logic              flag_plus,
    input  logic              flag_space,
    input  logic              flag_alt,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [6:0]        out_char,
    output logic              last
);
    import i2a_pkg::*;

    localparam logic [LEN_W-1:0] WMAX = LEN_W'(MAX_WIDTH);

    logic       busy_reg;
    fld_spec_t  spec_reg;
    fld_spec_t  spec_next;
    conv_stat_t stat;
    logic       start;
    logic       shift;
    logic       done;
    logic [31:0] mag;
    logic       force_p;

    assign in_ready = !busy_reg;
    assign start    = in_valid && in_ready;

    always_comb
    begin
        spec_next       = '0;
        force_p         = 1'b0;
        spec_next.base  = BASE_DEC;
        spec_next.alt   = flag_alt;
        unique case (func)
            FUNC_SDEC:
            begin
                spec_next.neg = value[31];
            end
            FUNC_HEXL:
            begin
                spec_next.base = BASE_HEX;
            end
            FUNC_HEXU:
            begin
                spec_next.base  = BASE_HEX;
                spec_next.upper = 1'b1;
            end
            FUNC_OCT:
            begin
                spec_next.base = BASE_OCT;
            end
            FUNC_PTR:
            begin
                spec_next.base = BASE_HEX;
                spec_next.alt  = 1'b1;
                force_p        = 1'b1;
            end
            default:
            begin
                spec_next.base = BASE_DEC;
            end
        endcase
        spec_next.plus      = flag_plus;
        spec_next.space     = flag_space;
        spec_next.left      = flag_left;
        spec_next.zflag     = flag_zero;
        spec_next.prec_none = !force_p && precision[6];
        if (force_p)
        begin
            spec_next.prec = PREC_PTR;
        end
        else
        begin
            spec_next.prec = (precision[5:0] > PREC_MAX) ? PREC_MAX : precision[5:0];
        end
        spec_next.width = (width > WMAX) ? WMAX : width;
    end

    assign mag = spec_next.neg ? (32'd0 - value) : value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            spec_reg <= spec_next;
        end
    end

    i2a_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .base_sel (spec_next.base),
        .mag      (mag),
        .shift    (shift),
        .stat     (stat)
    );

    i2a_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .spec      (spec_reg),
        .stat      (stat),
        .shift     (shift),
        .done      (done),
        .out_char  (out_char),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

@@ bench/tb_integer_to_ascii_field_formatter.sv @@
`timescale 1ns / 100ps
// testbench for the integer to ascii field formatter: directed and random fields checked per character
module tb_integer_to_ascii_field_formatter;

    import i2a_pkg::*;

    localparam logic [2:0] FUNC_RSV6 = 3'd6;
    localparam logic [2:0] FUNC_RSV7 = 3'd7;

    localparam logic signed [6:0] PREC_NONE = -7'sd1;
    localparam logic signed [6:0] PREC_NEG_MIN = 7'sb100_0000;
    localparam logic signed [6:0] PREC_TOP = 7'sd63;

    localparam logic [4:0] F_NONE  = 5'b00000;
    localparam logic [4:0] F_LEFT  = 5'b10000;
    localparam logic [4:0] F_ZERO  = 5'b01000;
    localparam logic [4:0] F_PLUS  = 5'b00100;
    localparam logic [4:0] F_SPACE = 5'b00010;
    localparam logic [4:0] F_ALT   = 5'b00001;

    localparam int RANDOM_FIELDS = 380;
    localparam int CYCLE_LIMIT   = 5000000;
    localparam int TAIL_CYCLES   = 150;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] value;
        logic [5:0]  width;
        logic [6:0]  precision;
        logic        left;
        logic        zero;
        logic        plus;
        logic        space;
        logic        alt;
    } field_req_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } field_char_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        func;
    logic [31:0]       value;
    logic [5:0]        width;
    logic signed [6:0] precision;
    logic              flag_left;
    logic              flag_zero;
    logic              flag_plus;
    logic              flag_space;
    logic              flag_alt;
    logic              out_valid;
    logic              out_ready;
    logic [6:0]        out_char;
    logic              last;

    field_char_t pending_chars[$];
    field_char_t exp_char;
    int          err_count;
    int          cycle_count;
    int          stall_left;
    bit          gaps_on;
    bit          stalls_on;

    integer_to_ascii_field_formatter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .value      (value),
        .width      (width),
        .precision  (precision),
        .flag_left  (flag_left),
        .flag_zero  (flag_zero),
        .flag_plus  (flag_plus),
        .flag_space (flag_space),
        .flag_alt   (flag_alt),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic field_req_t field(input logic [2:0] f, input logic [31:0] v,
                                         input logic [5:0] w, input logic signed [6:0] p,
                                         input logic [4:0] fl);
        field_req_t r;
        r.func = f;
        r.value = v;
        r.width = w;
        r.precision = p;
        {r.left, r.zero, r.plus, r.space, r.alt} = fl;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            return 0;
        end
        if (p < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // expected characters of one formatted field
    function automatic void predict_field(input field_req_t r);
        int          prec;
        int          fw;
        int          count;
        int          zeros;
        int          prefix;
        int          body;
        logic [31:0] base;
        logic [31:0] mag;
        logic [31:0] v;
        logic [31:0] d;
        bit          upper;
        bit          neg;
        bit          alt;
        bit          has_sign;
        logic [6:0]  sign_ch;
        logic [6:0]  digits [12];
        logic [6:0]  text [$];
        field_char_t c;
        fw = int'(r.width);
        if (r.precision[6])
        begin
            prec = -1;
        end
        else if (r.precision[5:0] > PREC_MAX)
        begin
            prec = int'(PREC_MAX);
        end
        else
        begin
            prec = int'(r.precision[5:0]);
        end
        base = 32'd10;
        upper = 1'b0;
        neg = 1'b0;
        mag = r.value;
        alt = r.alt;
        case (r.func)
            FUNC_SDEC:
            begin
                neg = r.value[31];
                mag = neg ? 32'd0 - r.value : r.value;
            end
            FUNC_HEXL:
            begin
                base = 32'd16;
            end
            FUNC_HEXU:
            begin
                base = 32'd16;
                upper = 1'b1;
            end
            FUNC_OCT:
            begin
                base = 32'd8;
            end
            FUNC_PTR:
            begin
                base = 32'd16;
                alt = 1'b1;
                prec = int'(PREC_PTR);
            end
            default:
            begin
            end
        endcase
        count = 0;
        v = mag;
        do
        begin
            d = v % base;
            if (d < 32'd10)
            begin
                digits[count] = CH_ZERO + d[6:0];
            end
            else
            begin
                digits[count] = (upper ? CH_A_UP : CH_A_LO) + d[6:0] - 7'd10;
            end
            count++;
            v = v / base;
        end
        while (v != 32'd0 && count < 12);
        if (prec == 0 && mag == 32'd0)
        begin
            count = 0;
        end
        zeros = (prec > count) ? prec - count : 0;
        has_sign = 1'b1;
        sign_ch = CH_SPACE;
        if (neg)
        begin
            sign_ch = CH_MINUS;
        end
        else if (r.plus)
        begin
            sign_ch = CH_PLUS;
        end
        else if (!r.space)
        begin
            has_sign = 1'b0;
        end
        prefix = 0;
        if (alt && base == 32'd16 && mag != 32'd0)
        begin
            prefix = 2;
        end
        else if (alt && base == 32'd8 && zeros == 0 && (mag != 32'd0 || count == 0))
        begin
            prefix = 1;
        end
        body = count + zeros + int'(has_sign) + prefix;
        if (!r.left)
        begin
            if (r.zero && prec < 0 && fw > body)
            begin
                zeros += fw - body;
                body = fw;
            end
            else
            begin
                for (int i = body; i < fw; i++)
                begin
                    text.push_back(CH_SPACE);
                end
            end
        end
        if (has_sign)
        begin
            text.push_back(sign_ch);
        end
        if (prefix >= 1)
        begin
            text.push_back(CH_ZERO);
        end
        if (prefix == 2)
        begin
            text.push_back(upper ? CH_X_UP : CH_X_LO);
        end
        repeat (zeros) text.push_back(CH_ZERO);
        for (int k = count - 1; k >= 0; k--)
        begin
            text.push_back(digits[k]);
        end
        if (r.left)
        begin
            for (int i = body; i < fw; i++)
            begin
                text.push_back(CH_SPACE);
            end
        end
        foreach (text[k])
        begin
            c.ch = text[k];
            c.last = (k == text.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic field_req_t random_field();
        field_req_t r;
        case ($urandom_range(0, 5))
            0: r.value = $urandom;
            1: r.value = $urandom_range(0, 20);
            2: r.value = 32'd0 - $urandom_range(0, 20);
            3: r.value = 32'h7fff_fffe + $urandom_range(0, 3);
            4: r.value = $urandom >> $urandom_range(0, 31);
            default: r.value = 32'd0;
        endcase
        r.func = 3'($urandom_range(0, 7));
        r.width = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) :
                                                6'($urandom_range(0, 12));
        case ($urandom_range(0, 4))
            0: r.precision = PREC_NONE;
            1: r.precision = 7'h40 | 7'($urandom_range(0, 63));
            2: r.precision = 7'($urandom_range(0, 63));
            default: r.precision = 7'($urandom_range(0, 8));
        endcase
        {r.left, r.zero, r.plus, r.space, r.alt} = 5'($urandom_range(0, 31));
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_field(input field_req_t r);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func = r.func;
        value = r.value;
        width = r.width;
        precision = r.precision;
        flag_left = r.left;
        flag_zero = r.zero;
        flag_plus = r.plus;
        flag_space = r.space;
        flag_alt = r.alt;
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_field(r);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic test_conversions();
        send_field(field(FUNC_SDEC, 32'h8000_0000, 6'd0, PREC_NONE, F_NONE));
        send_field(field(FUNC_UDEC, 32'hffff_ffff, 6'd0, PREC_NONE, F_NONE));
        send_field(field(FUNC_HEXL, 32'hdead_beef, 6'd0, PREC_NONE, F_NONE));
        send_field(field(FUNC_HEXU, 32'hdead_beef, 6'd0, PREC_NONE, F_ALT));
        send_field(field(FUNC_OCT, 32'hffff_ffff, 6'd0, PREC_NONE, F_ALT));
        send_field(field(FUNC_PTR, 32'h0000_1234, 6'd0, PREC_NONE, F_NONE));
        send_field(field(FUNC_RSV6, 32'h7fff_ffff, 6'd0, PREC_NONE, F_NONE));
        send_field(field(FUNC_RSV7, 32'hffff_fff6, 6'd0, PREC_NONE, F_NONE));
    endtask

    task automatic test_sign_flags();
        send_field(field(FUNC_HEXL, 32'h0000_001f, 6'd0, PREC_NONE, F_PLUS | F_SPACE));
        send_field(field(FUNC_OCT, 32'h0000_0009, 6'd4, PREC_NONE, F_SPACE));
    endtask

    task automatic test_precision();
        send_field(field(FUNC_UDEC, 32'd7, 6'd0, PREC_TOP, F_NONE));
        send_field(field(FUNC_SDEC, 32'hffff_ff85, 6'd10, PREC_NEG_MIN, F_ZERO));
        send_field(field(FUNC_HEXU, 32'h0000_00ab, 6'd10, 7'sd6, F_ALT | F_ZERO));
    endtask

    task automatic test_width();
        send_field(field(FUNC_SDEC, 32'hffff_ffff, 6'd63, PREC_NONE, F_NONE));
        send_field(field(FUNC_HEXL, 32'h00c0_ffee, 6'd63, PREC_NONE, F_LEFT | F_ZERO));
        send_field(field(FUNC_HEXL, 32'h0000_0abc, 6'd12, PREC_NONE, F_ZERO | F_PLUS | F_ALT));
    endtask

    task automatic test_alt_forms();
        send_field(field(FUNC_OCT, 32'd0, 6'd0, 7'sd0, F_ALT));
        send_field(field(FUNC_HEXL, 32'd0, 6'd0, PREC_NONE, F_ALT));
        send_field(field(FUNC_PTR, 32'd0, 6'd0, PREC_NONE, F_NONE));
    endtask

    task automatic test_empty_field();
        send_field(field(FUNC_SDEC, 32'd0, 6'd0, 7'sd0, F_NONE));
        send_field(field(FUNC_UDEC, 32'd0, 6'd5, 7'sd0, F_LEFT));
    endtask

    task automatic test_random_fields();
        for (int n = 0; n < RANDOM_FIELDS; n++)
        begin
            if (n % 40 == 0)
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            if (n % 95 == 94)
            begin
                wait_drained();
            end
            send_field(random_field());
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (stalls_on && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                err_count++;
                if (err_count <= 50)
                begin
                    $display("%0t: expected no transaction, actual out_char %h last %b",
                             $time, out_char, last);
                end
            end
            else
            begin
                exp_char = pending_chars.pop_front();
                if (out_char !== exp_char.ch)
                begin
                    err_count++;
                    if (err_count <= 50)
                    begin
                        $display("%0t: out_char expected %h actual %h",
                                 $time, exp_char.ch, out_char);
                    end
                end
                if (last !== exp_char.last)
                begin
                    err_count++;
                    if (err_count <= 50)
                    begin
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_char.last, last);
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = FUNC_SDEC;
        value = 32'd0;
        width = 6'd0;
        precision = PREC_NONE;
        flag_left = 1'b0;
        flag_zero = 1'b0;
        flag_plus = 1'b0;
        flag_space = 1'b0;
        flag_alt = 1'b0;
        err_count = 0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_conversions();
        test_sign_flags();
        test_precision();
        test_width();
        test_alt_forms();
        test_empty_field();
        wait_drained();
        test_random_fields();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_chars.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
